// ===== rtl/pngx_pkg.sv =====
// ----------------------------------------------------------------------------
// pngx_pkg: shared types and constants for the PNG text chunk extractor
// Holds the result item type, result kinds and the output queue sizing.
// ----------------------------------------------------------------------------
package pngx_pkg;

    // result kinds
    localparam logic [2:0] KIND_KEY     = 3'd0;
    localparam logic [2:0] KIND_VALUE   = 3'd1;
    localparam logic [2:0] KIND_COMMIT  = 3'd2;
    localparam logic [2:0] KIND_DISCARD = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    // output queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
    } pngx_res_t;

    typedef struct packed {
        logic [QAW:0] level;
        logic         room2;
    } pngx_qstat_t;

endpackage

// ===== rtl/pngx_parser.sv =====
// ----------------------------------------------------------------------------
// pngx_parser: PNG signature and chunk walker
// Updates the parse state on each accepted item and produces zero, one or
// two result items for that item.
// ----------------------------------------------------------------------------
module pngx_parser
    import pngx_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic            eof,
    input  logic [7:0]      data_byte,
    output logic [1:0]      res_cnt,
    output pngx_res_t       res0,
    output pngx_res_t       res1
);

    localparam logic [2:0] PH_SIG  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRC  = 3'd4;
    localparam logic [2:0] PH_STOP = 3'd5;

    localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h89;
            3'd1:    v = 8'h50;
            3'd2:    v = 8'h4e;
            3'd3:    v = 8'h47;
            3'd4:    v = 8'h0d;
            3'd5:    v = 8'h0a;
            3'd6:    v = 8'h1a;
            default: v = 8'h0a;
        endcase
        return v;
    endfunction

    logic [2:0]  phase_reg,  phase_next;
    logic [2:0]  cnt_reg,    cnt_next;
    logic [31:0] len_reg,    len_next;
    logic [31:0] rem_reg,    rem_next;
    logic [31:0] type_reg,   type_next;
    logic        text_reg,   text_next;
    logic        sep_reg,    sep_next;
    logic        pend_reg,   pend_next;
    logic [31:0] type_shift;

    assign type_shift = {type_reg[23:0], data_byte};

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        type_next  = type_reg;
        text_next  = text_reg;
        sep_next   = sep_reg;
        pend_next  = pend_reg;
        res_cnt    = 2'd0;
        res0       = '0;
        res1       = '0;
        if (eof) begin
            if (pend_reg) begin
                res0    = '{kind: KIND_DISCARD, data: 8'd0, last: 1'b0};
                res1    = '{kind: KIND_END,     data: 8'd0, last: 1'b1};
                res_cnt = 2'd2;
            end else begin
                res0    = '{kind: KIND_END, data: 8'd0, last: 1'b1};
                res_cnt = 2'd1;
            end
            // back to the reset state for the next file
            phase_next = PH_SIG;
            cnt_next   = 3'd0;
            len_next   = 32'd0;
            rem_next   = 32'd0;
            type_next  = 32'd0;
            text_next  = 1'b0;
            sep_next   = 1'b0;
            pend_next  = 1'b0;
        end else begin
            unique case (phase_reg)
                PH_SIG: begin
                    if (data_byte != sig_byte(cnt_reg)) begin
                        phase_next = PH_STOP;
                        cnt_next   = 3'd0;
                    end else if (cnt_reg == 3'd7) begin
                        phase_next = PH_LEN;
                        cnt_next   = 3'd0;
                        len_next   = 32'd0;
                    end else begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_LEN: begin
                    len_next = {len_reg[23:0], data_byte};
                    if (cnt_reg == 3'd3) begin
                        phase_next = PH_TYPE;
                        cnt_next   = 3'd0;
                        type_next  = 32'd0;
                    end else begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_TYPE: begin
                    type_next = type_shift;
                    if (cnt_reg == 3'd3) begin
                        cnt_next = 3'd0;
                        if (type_shift == TYPE_IEND) begin
                            phase_next = PH_STOP;
                        end else begin
                            text_next  = (type_shift == TYPE_TEXT);
                            sep_next   = 1'b0;
                            pend_next  = (type_shift == TYPE_TEXT);
                            rem_next   = len_reg;
                            phase_next = (len_reg == 32'd0) ? PH_CRC : PH_DATA;
                        end
                    end else begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_DATA: begin
                    if (text_reg) begin
                        // the first NUL splits key from value and is dropped
                        if (!sep_reg && data_byte == 8'd0) begin
                            sep_next = 1'b1;
                        end else begin
                            res0.kind = sep_reg ? KIND_VALUE : KIND_KEY;
                            res0.data = data_byte;
                            res0.last = 1'b1;
                            res_cnt   = 2'd1;
                        end
                    end
                    rem_next = rem_reg - 32'd1;
                    if (rem_reg == 32'd1) begin
                        phase_next = PH_CRC;
                        cnt_next   = 3'd0;
                    end
                end
                PH_CRC: begin
                    if (cnt_reg == 3'd3) begin
                        if (pend_reg) begin
                            res0.kind = sep_reg ? KIND_COMMIT : KIND_DISCARD;
                            res0.last = 1'b1;
                            res_cnt   = 2'd1;
                        end
                        pend_next  = 1'b0;
                        text_next  = 1'b0;
                        sep_next   = 1'b0;
                        phase_next = PH_LEN;
                        cnt_next   = 3'd0;
                        len_next   = 32'd0;
                    end else begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SIG;
            cnt_reg   <= 3'd0;
            len_reg   <= 32'd0;
            rem_reg   <= 32'd0;
            type_reg  <= 32'd0;
            text_reg  <= 1'b0;
            sep_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            type_reg  <= type_next;
            text_reg  <= text_next;
            sep_reg   <= sep_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// ===== rtl/pngx_out_fifo.sv =====
// ----------------------------------------------------------------------------
// pngx_out_fifo: result queue
// Takes up to two result items per cycle and hands out one per cycle.
// ----------------------------------------------------------------------------
module pngx_out_fifo
    import pngx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  push_cnt,
    input  pngx_res_t   push0,
    input  pngx_res_t   push1,
    input  logic        pop,
    output pngx_res_t   head,
    output logic        not_empty,
    output pngx_qstat_t stat
);

    pngx_res_t      mem [QDEPTH];
    logic [QAW-1:0] wptr_reg, wptr_next;
    logic [QAW-1:0] rptr_reg, rptr_next;
    logic [QAW:0]   cnt_reg,  cnt_next;
    logic [QAW-1:0] wptr_p1;

    assign wptr_p1   = wptr_reg + QAW'(1);
    assign wptr_next = wptr_reg + QAW'(push_cnt);
    assign rptr_next = rptr_reg + QAW'(pop);
    assign cnt_next  = cnt_reg + (QAW+1)'(push_cnt) - (QAW+1)'(pop);

    assign head       = mem[rptr_reg];
    assign not_empty  = (cnt_reg != '0);
    assign stat.level = cnt_reg;
    assign stat.room2 = (cnt_reg <= (QAW+1)'(QDEPTH - 2));

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem[wptr_p1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== rtl/png_text_chunk_extractor.sv =====
// ----------------------------------------------------------------------------
// png_text_chunk_extractor: tEXt key/value extractor for a PNG byte stream
// Results are queued as their inputs are taken. Throughput: one input item per
// cycle while s_tready is high; end of file with an open entry gives two result
// items, which drain one per cycle from a four-entry queue while m_tready is
// high. s_tready drops only while the queue has fewer than two free entries.
// Reset (aresetn low, synchronous): parser back to signature check, queue empty.
// ----------------------------------------------------------------------------
module png_text_chunk_extractor
    import pngx_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [0:0] s_tuser,   // [0] operation (1 = end of file)
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [2:0] kind
    output logic       m_tlast
);

    logic        s_accept;
    logic [1:0]  res_cnt;
    pngx_res_t   res0;
    pngx_res_t   res1;
    pngx_res_t   head;
    pngx_qstat_t qstat;

    assign s_tready = qstat.room2;
    assign s_accept = s_tvalid && s_tready;

    pngx_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .eof       (s_tuser[0]),
        .data_byte (s_tdata),
        .res_cnt   (res_cnt),
        .res0      (res0),
        .res1      (res1)
    );

    pngx_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (s_accept ? res_cnt : 2'd0),
        .push0     (res0),
        .push1     (res1),
        .pop       (m_tvalid && m_tready),
        .head      (head),
        .not_empty (m_tvalid),
        .stat      (qstat)
    );

    assign m_tdata = head.data;
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    // end of file always leaves a result waiting
    a_eof_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser[0] |=> m_tvalid)
        else $error("end of file item left no result");

    // stream ended is always the final result of its item
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_END |-> m_tlast)
        else $error("stream ended result without last");

    // key and value bytes are always the only result of their item
    a_byte_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_KEY || m_tuser == KIND_VALUE) |-> m_tlast)
        else $error("key or value byte without last");

    // queue never overfills
    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.level <= (QAW+1)'(QDEPTH))
        else $error("result queue overflow");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for png_text_chunk_extractor
// Streams PNG files built from random chunks through the block and checks
// each result item against a cycle-free parser model kept in the bench.
// ----------------------------------------------------------------------------
module tb;
    import pngx_pkg::*;

    localparam logic [31:0] TYPE_TEXT = 32'h74455874;
    localparam logic [31:0] TYPE_IEND = 32'h49454E44;
    localparam logic [31:0] TYPE_IHDR = 32'h49484452;
    localparam logic [7:0]  PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                            8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic        OP_BYTE = 1'b0;
    localparam logic        OP_EOF  = 1'b1;
    localparam int          HOLD_CYCLES = 200;

    typedef enum logic [2:0] {
        P_SIG, P_LEN, P_TYPE, P_DATA, P_CRC, P_STOP
    } parse_phase_t;

    typedef struct packed {
        logic       op;
        logic [7:0] b;
    } file_item_t;

    typedef logic [7:0] byte_q_t[$];

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic [0:0] s_tuser = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    png_text_chunk_extractor u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    file_item_t  file_items[$];
    pngx_res_t   due_results[$];
    byte_q_t     file_buf;
    int          items_queued = 0;
    int          mismatches = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    logic        rx_hold_start = 1'b0;
    int unsigned rx_hold_left = 0;

    // parser state
    parse_phase_t ph;
    logic [2:0]   ph_cnt;
    logic [31:0]  chunk_len;
    logic [31:0]  data_left;
    logic [31:0]  chunk_kind;
    logic         in_text;
    logic         sep_seen;
    logic         entry_open;

    function automatic void clear_parser();
        ph         = P_SIG;
        ph_cnt     = 3'd0;
        chunk_len  = 32'd0;
        data_left  = 32'd0;
        chunk_kind = 32'd0;
        in_text    = 1'b0;
        sep_seen   = 1'b0;
        entry_open = 1'b0;
    endfunction

    function automatic void note_result(logic [2:0] kind, logic [7:0] b, logic last);
        pngx_res_t r;
        r.kind = kind;
        r.data = b;
        r.last = last;
        due_results = {due_results, r};
    endfunction

    function automatic void parse_png_item(logic op, logic [7:0] b);
        if (op == OP_EOF) begin
            if (entry_open)
                note_result(KIND_DISCARD, 8'h00, 1'b0);
            note_result(KIND_END, 8'h00, 1'b1);
            clear_parser();
            return;
        end
        case (ph)
            P_SIG: begin
                if (b != PNG_SIG[ph_cnt]) begin
                    ph = P_STOP;
                    ph_cnt = 3'd0;
                end else if (ph_cnt == 3'd7) begin
                    ph = P_LEN;
                    ph_cnt = 3'd0;
                    chunk_len = 32'd0;
                end else begin
                    ph_cnt++;
                end
            end
            P_LEN: begin
                chunk_len = {chunk_len[23:0], b};
                if (ph_cnt == 3'd3) begin
                    ph = P_TYPE;
                    ph_cnt = 3'd0;
                    chunk_kind = 32'd0;
                end else begin
                    ph_cnt++;
                end
            end
            P_TYPE: begin
                chunk_kind = {chunk_kind[23:0], b};
                if (ph_cnt == 3'd3) begin
                    ph_cnt = 3'd0;
                    if (chunk_kind == TYPE_IEND) begin
                        ph = P_STOP;
                    end else begin
                        in_text    = (chunk_kind == TYPE_TEXT);
                        sep_seen   = 1'b0;
                        entry_open = in_text;
                        data_left  = chunk_len;
                        ph = (data_left == 32'd0) ? P_CRC : P_DATA;
                    end
                end else begin
                    ph_cnt++;
                end
            end
            P_DATA: begin
                if (in_text) begin
                    // the first NUL splits key from value and is dropped
                    if (!sep_seen && b == 8'h00)
                        sep_seen = 1'b1;
                    else
                        note_result(sep_seen ? KIND_VALUE : KIND_KEY, b, 1'b1);
                end
                data_left--;
                if (data_left == 32'd0) begin
                    ph = P_CRC;
                    ph_cnt = 3'd0;
                end
            end
            P_CRC: begin
                if (ph_cnt == 3'd3) begin
                    if (entry_open)
                        note_result(sep_seen ? KIND_COMMIT : KIND_DISCARD, 8'h00, 1'b1);
                    entry_open = 1'b0;
                    in_text    = 1'b0;
                    sep_seen   = 1'b0;
                    ph         = P_LEN;
                    ph_cnt     = 3'd0;
                    chunk_len  = 32'd0;
                end else begin
                    ph_cnt++;
                end
            end
            default: ;
        endcase
    endfunction

    // driver: offer the head of file_items, advance on each accepted item
    always @(posedge aclk) begin : driver
        bit offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_png_item(file_items[0].op, file_items[0].b);
                void'(file_items.pop_front());
                offer = file_items.size() != 0 && $urandom_range(99) >= src_idle_pct;
            end else if (s_tvalid) begin
                offer = 1'b1;
            end else begin
                offer = file_items.size() != 0 && $urandom_range(99) >= src_idle_pct;
            end
            s_tvalid <= offer;
            if (offer) begin
                s_tdata  <= file_items[0].b;
                s_tuser  <= file_items[0].op;
            end
        end
    end

    always @(posedge aclk) begin
        if (rx_hold_start)
            rx_hold_left <= HOLD_CYCLES;
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : monitor
        pngx_res_t got;
        pngx_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind = m_tuser;
                got.data = m_tdata;
                got.last = m_tlast;
                if (due_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got %p", $time, got);
                end else begin
                    want = due_results.pop_front();
                    if (got != want) begin
                        mismatches++;
                        $display("%0t: mismatch: expected %p, got %p", $time, want, got);
                    end
                end
            end
            m_tready <= !rx_hold_start && rx_hold_left == 0 &&
                        $urandom_range(99) >= snk_stall_pct;
        end
    end

    task automatic add_item(logic op, logic [7:0] b);
        file_item_t it;
        it.op = op;
        it.b  = b;
        file_items = {file_items, it};
        items_queued++;
    endtask

    task automatic put_sig();
        foreach (PNG_SIG[i])
            file_buf = {file_buf, PNG_SIG[i]};
    endtask

    task automatic put_word(logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            file_buf = {file_buf, w[8*i +: 8]};
    endtask

    task automatic put_chunk(logic [31:0] kind, byte_q_t body, logic [31:0] len_word);
        put_word(len_word);
        put_word(kind);
        foreach (body[i])
            file_buf = {file_buf, body[i]};
        put_word($urandom());
    endtask

    // send the first keep bytes of file_buf, then end of file
    task automatic ship_file(int keep);
        for (int i = 0; i < keep; i++)
            add_item(OP_BYTE, file_buf[i]);
        add_item(OP_EOF, 8'($urandom_range(255)));
        file_buf.delete();
    endtask

    function automatic byte_q_t text_body(int len);
        byte_q_t body;
        int      nul_pos;
        nul_pos = ($urandom_range(6) == 0) ? -1 : $urandom_range(0, len);
        for (int i = 0; i < len; i++) begin
            if (i == nul_pos)
                body = {body, 8'h00};
            else if (nul_pos < 0 || i < nul_pos)
                body = {body, 8'($urandom_range(1, 255))};
            else if ($urandom_range(7) == 0)
                body = {body, 8'h00};
            else
                body = {body, 8'($urandom_range(255))};
        end
        return body;
    endfunction

    task automatic random_file();
        byte_q_t     body;
        int          pick;
        int          len;
        logic [31:0] kind;
        logic [31:0] len_word;
        pick = $urandom_range(99);
        if (pick < 8) begin
            // noise: random bytes that almost never form a signature
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                file_buf = {file_buf, 8'($urandom_range(255))};
        end else begin
            put_sig();
            if (pick < 14)
                file_buf[$urandom_range(7)] = 8'($urandom_range(255));
            for (int c = $urandom_range(0, 4); c > 0; c--) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
                pick = $urandom_range(99);
                body.delete();
                if (pick < 60) begin
                    kind = TYPE_TEXT;
                    body = text_body(len);
                end else if (pick < 70) begin
                    kind = TYPE_IEND;
                    len = 0;
                end else begin
                    kind = ($urandom_range(1) == 0) ? TYPE_IHDR : 32'($urandom());
                    for (int i = 0; i < len; i++)
                        body = {body, 8'($urandom_range(255))};
                end
                // a broken length runs the data phase on until end of file
                len_word = ($urandom_range(32) == 0) ? 32'($urandom()) : 32'(len);
                put_chunk(kind, body, len_word);
            end
        end
        if ($urandom_range(99) < 15)
            ship_file($urandom_range(0, file_buf.size() - 1));
        else
            ship_file(file_buf.size());
    endtask

    task wait_drained();
        do
            @(negedge aclk);
        while (file_items.size() != 0 || due_results.size() != 0);
    endtask

    initial begin
        byte_q_t body;
        int      goal;
        clear_parser();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // lone end of file, ignored byte all ones
        add_item(OP_EOF, 8'hFF);
        // bad signature at the second byte; the rest is ignored
        add_item(OP_BYTE, 8'h89);
        add_item(OP_BYTE, 8'hFF);
        add_item(OP_BYTE, 8'h00);
        add_item(OP_EOF, 8'h00);
        // key, separator, NUL value byte; empty text; skipped chunk; early end
        put_sig();
        body = {8'h6B, 8'h00, 8'h00};
        put_chunk(TYPE_TEXT, body, 32'd3);
        body.delete();
        put_chunk(TYPE_TEXT, body, 32'd0);
        body = {8'hFF};
        put_chunk(TYPE_IHDR, body, 32'd1);
        put_word(32'd2);
        put_word(TYPE_TEXT);
        file_buf = {file_buf, 8'h41};
        file_buf = {file_buf, 8'hFF};
        ship_file(file_buf.size());
        // end chunk stops parsing
        put_sig();
        body.delete();
        put_chunk(TYPE_IEND, body, 32'd0);
        file_buf = {file_buf, 8'h00};
        file_buf = {file_buf, 8'hFF};
        ship_file(file_buf.size());
        wait_drained();

        goal = items_queued;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 80; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 80; end
                default: begin src_idle_pct = 22; snk_stall_pct = 22; end
            endcase
            goal += 250;
            while (items_queued < goal)
                random_file();
            wait_drained();

            if (p == 0) begin
                // hold off the receiver while a long text chunk streams in
                rx_hold_start = 1'b1;
                @(negedge aclk);
                rx_hold_start = 1'b0;
                put_sig();
                body.delete();
                for (int i = 0; i < 40; i++)
                    body = {body, 8'($urandom_range(1, 255))};
                put_chunk(TYPE_TEXT, body, 32'd40);
                ship_file(file_buf.size());
                wait_drained();
            end
        end

        repeat (10) @(negedge aclk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
